/* hw/rtl/glob_wildcard_filter_macros.svh */
// Assertion macros used by the glob wildcard filter checker.
`ifndef GLOB_WILDCARD_FILTER_MACROS_SVH
`define GLOB_WILDCARD_FILTER_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define GWF_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication check failed");

// Next-cycle implication, disabled while reset is high.
`define GWF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication check failed");

`endif

/* hw/rtl/gwf_pkg.sv */
// Package with constants, codes and shared types of the glob wildcard filter.
package gwf_pkg;

   localparam int FILTER_COUNT = 3;
   localparam int PATTERN_MAX  = 32;
   localparam int POS_W        = $clog2(PATTERN_MAX);
   localparam int LEN_W        = 6;
   localparam int CHAR_W       = 8;

   localparam logic [CHAR_W-1:0] STAR_CHAR = 8'h2A;
   localparam logic [CHAR_W-1:0] ANY_CHAR  = 8'h3F;
   localparam logic [CHAR_W-1:0] NUL_CHAR  = 8'h00;

   typedef enum logic [1:0] {
      FUNC_WRITE = 2'd0,
      FUNC_NAME  = 2'd1,
      FUNC_END   = 2'd2
   } func_type;

   typedef enum logic [1:0] {
      CSR_ENABLE = 2'd0,
      CSR_LEN_A  = 2'd1,
      CSR_LEN_B  = 2'd2,
      CSR_LEN_C  = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic start;
      logic name;
      logic fin;
      logic len_wr;
      logic byte_wr;
   } slot_ctrl_type;

   typedef struct packed {
      logic star;
      logic star_nxt;
      logic nz_nxt;
      logic src;
      logic adv;
      logic raw;
   } cell_out_type;

endpackage

/* hw/rtl/gwf_cell.sv */
// One pattern position: stored pattern byte, active flag and local match step.
module gwf_cell (
   input  logic                        clock,
   input  logic                        reset,
   input  gwf_pkg::slot_ctrl_type      ctrl,
   input  logic                        byte_wr,
   input  logic [gwf_pkg::CHAR_W-1:0]  char_value,
   input  logic                        start_bit,
   input  logic                        in_range,
   input  logic                        adv_prev,
   input  logic                        reach_prev,
   output gwf_pkg::cell_out_type       flags
);

   logic [gwf_pkg::CHAR_W-1:0] byte_ff;
   logic [gwf_pkg::CHAR_W-1:0] byte_in;
   logic                       act_ff;
   logic                       act_in;
   logic                       src;
   logic                       star;
   logic                       lit_hit;
   logic                       go;
   logic                       keep;
   logic                       adv;
   logic                       raw;

   always_comb begin
      byte_in = byte_wr ? char_value : byte_ff;
      src     = ctrl.start ? start_bit : act_ff;
      star    = (byte_ff == gwf_pkg::STAR_CHAR);
      lit_hit = (byte_ff == char_value) || (byte_ff == gwf_pkg::ANY_CHAR);
      go      = src & in_range;
      keep    = go & star;
      adv     = go & ~star & lit_hit;
      raw     = keep | adv_prev;
   end

   always_comb begin
      if (ctrl.fin) begin
         act_in = 1'b0;
      end else if (ctrl.name) begin
         act_in = raw | reach_prev;
      end else begin
         act_in = act_ff;
      end
   end

   always_comb begin
      flags.star     = star;
      flags.star_nxt = (byte_in == gwf_pkg::STAR_CHAR);
      flags.nz_nxt   = (byte_in != gwf_pkg::NUL_CHAR);
      flags.src      = src;
      flags.adv      = adv;
      flags.raw      = raw;
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff <= 1'b0;
      end else begin
         act_ff <= act_in;
      end
   end

endmodule

/* hw/rtl/gwf_slot.sv */
// One filter slot: a row of pattern cells, the end position, length and star closure.
module gwf_slot (
   input  logic                        clock,
   input  logic                        reset,
   input  gwf_pkg::slot_ctrl_type      ctrl,
   input  logic [gwf_pkg::POS_W-1:0]   pattern_position,
   input  logic [gwf_pkg::CHAR_W-1:0]  char_value,
   input  logic [gwf_pkg::LEN_W-1:0]   len_wdata,
   output logic                        hit
);

   localparam int PM = gwf_pkg::PATTERN_MAX;

   gwf_pkg::cell_out_type         cell_flags [PM];
   logic [PM-1:0]                 cell_wr;
   logic [PM-1:0]                 star_cur;
   logic [PM-1:0]                 star_nxt;
   logic [PM-1:0]                 nz_nxt;
   logic [PM-1:0]                 src_vec;
   logic [PM-1:0]                 adv_vec;
   logic [PM-1:0]                 raw_vec;
   logic [PM-1:0]                 len_mask_in;
   logic [PM-1:0]                 nz_run;
   logic [PM-1:0]                 star_run;
   logic [PM-1:0]                 range_ff;
   logic [PM-1:0]                 range_in;
   logic [PM:0]                   start_ff;
   logic [PM:0]                   start_in;
   logic [PM-1:0]                 prop;
   logic [PM-1:0]                 seed_sum;
   logic [PM-1:0]                 reach;
   logic [PM-1:0]                 end_vec;
   logic [gwf_pkg::LEN_W-1:0]     len_ff;
   logic [gwf_pkg::LEN_W-1:0]     len_in;
   logic                          end_ff;
   logic                          end_in;
   logic                          end_src;

   genvar gi;
   generate
      for (gi = 0; gi < PM; gi++) begin : g_cell
         logic adv_prev;
         logic reach_prev;
         if (gi == 0) begin : g_first
            assign adv_prev   = 1'b0;
            assign reach_prev = 1'b0;
         end else begin : g_rest
            assign adv_prev   = cell_flags[gi-1].adv;
            assign reach_prev = reach[gi-1];
         end
         assign cell_wr[gi] = ctrl.byte_wr && (pattern_position == gwf_pkg::POS_W'(gi));
         gwf_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctrl       (ctrl),
            .byte_wr    (cell_wr[gi]),
            .char_value (char_value),
            .start_bit  (start_ff[gi]),
            .in_range   (range_ff[gi]),
            .adv_prev   (adv_prev),
            .reach_prev (reach_prev),
            .flags      (cell_flags[gi])
         );
      end
   endgenerate

   always_comb begin
      for (int i = 0; i < PM; i++) begin
         star_cur[i]    = cell_flags[i].star;
         star_nxt[i]    = cell_flags[i].star_nxt;
         nz_nxt[i]      = cell_flags[i].nz_nxt;
         src_vec[i]     = cell_flags[i].src;
         adv_vec[i]     = cell_flags[i].adv;
         raw_vec[i]     = cell_flags[i].raw;
         len_mask_in[i] = (gwf_pkg::LEN_W'(i) < len_in);
      end
   end

   always_comb begin
      len_in   = ctrl.len_wr ? len_wdata : len_ff;
      nz_run   = nz_nxt & len_mask_in;
      range_in = nz_run & ~(nz_run + PM'(1));
      star_run = star_nxt & len_mask_in;
      start_in = {star_run & ~(star_run + PM'(1)), 1'b1};
   end

   // Star closure: a reached star extends through the following run of stars.
   always_comb begin
      prop     = star_cur & range_ff;
      seed_sum = (raw_vec & prop) + prop;
      reach    = prop & (raw_vec | ~seed_sum);
   end

   always_comb begin
      if (ctrl.fin) begin
         end_in = 1'b0;
      end else if (ctrl.name) begin
         end_in = adv_vec[PM-1] | reach[PM-1];
      end else begin
         end_in = end_ff;
      end
   end

   always_comb begin
      end_vec = range_ff ^ {range_ff[PM-2:0], 1'b1};
      end_src = ctrl.start ? start_ff[PM] : end_ff;
      hit     = (|(src_vec & end_vec)) | (end_src & range_ff[PM-1]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff   <= '0;
         range_ff <= '0;
         start_ff <= (PM+1)'(1);
         end_ff   <= 1'b0;
      end else begin
         len_ff   <= len_in;
         range_ff <= range_in;
         start_ff <= start_in;
         end_ff   <= end_in;
      end
   end

endmodule

/* hw/rtl/glob_wildcard_filter.sv */
// The result is registered and valid in the cycle after the end-of-name transfer is taken.
// Throughput: one item per cycle while req_stall is low; each byte passes through the
// per-cell compare and one 32-bit star-closure add per slot combinationally.
// Reset (synchronous, active high) clears active positions, lengths, enables
// and the result valid flag, and marks a name start; the pattern bytes keep
// their contents and are defined only after they are written.
module glob_wildcard_filter (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [1:0]                          req_func,
   input  logic [1:0]                          req_filter_slot,
   input  logic [gwf_pkg::POS_W-1:0]           req_pattern_position,
   input  logic [gwf_pkg::CHAR_W-1:0]          req_char_value,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [gwf_pkg::FILTER_COUNT-1:0]    rsp_filter_hits,
   output logic                                rsp_any_hit,
   output logic                                rsp_accepted,
   input  logic                                csr_write,
   input  logic [1:0]                          csr_index,
   input  logic [gwf_pkg::LEN_W-1:0]           csr_wdata
);

   localparam int FC = gwf_pkg::FILTER_COUNT;

   gwf_pkg::func_type        func;
   gwf_pkg::slot_ctrl_type   slot_ctrl [FC];
   logic [FC-1:0]            slot_hit;
   logic [FC-1:0]            len_wr;
   logic [FC-1:0]            enable_ff;
   logic [FC-1:0]            enable_in;
   logic [FC-1:0]            hits;
   logic                     accept;
   logic                     take_write;
   logic                     take_name;
   logic                     take_end;
   logic                     start_ff;
   logic                     start_in;
   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   logic [FC-1:0]            hits_ff;
   logic                     any_ff;
   logic                     acc_ff;

   assign req_stall = rsp_valid_ff & rsp_stall;

   always_comb begin
      func       = gwf_pkg::func_type'(req_func);
      accept     = req_valid & ~req_stall;
      take_write = 1'b0;
      take_name  = 1'b0;
      take_end   = 1'b0;
      case (func)
         gwf_pkg::FUNC_WRITE: take_write = accept;
         gwf_pkg::FUNC_NAME:  take_name  = accept;
         gwf_pkg::FUNC_END:   take_end   = accept;
         default: ;
      endcase
   end

   always_comb begin
      len_wr    = '0;
      enable_in = enable_ff;
      case (gwf_pkg::csr_index_type'(csr_index))
         gwf_pkg::CSR_ENABLE: begin
            if (csr_write) enable_in = csr_wdata[FC-1:0];
         end
         gwf_pkg::CSR_LEN_A: len_wr[0] = csr_write;
         gwf_pkg::CSR_LEN_B: len_wr[1] = csr_write;
         gwf_pkg::CSR_LEN_C: len_wr[2] = csr_write;
         default: ;
      endcase
   end

   genvar gs;
   generate
      for (gs = 0; gs < FC; gs++) begin : g_slot
         always_comb begin
            slot_ctrl[gs].start   = start_ff;
            slot_ctrl[gs].name    = take_name;
            slot_ctrl[gs].fin     = take_end;
            slot_ctrl[gs].len_wr  = len_wr[gs];
            slot_ctrl[gs].byte_wr = take_write && (req_filter_slot == 2'(gs));
         end
         gwf_slot u_slot (
            .clock            (clock),
            .reset            (reset),
            .ctrl             (slot_ctrl[gs]),
            .pattern_position (req_pattern_position),
            .char_value       (req_char_value),
            .len_wdata        (csr_wdata),
            .hit              (slot_hit[gs])
         );
      end
   endgenerate

   always_comb begin
      hits = enable_ff & slot_hit;
      if (take_end) begin
         start_in = 1'b1;
      end else if (take_name) begin
         start_in = 1'b0;
      end else begin
         start_in = start_ff;
      end
      if (take_end) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff     <= 1'b1;
         enable_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         start_ff     <= start_in;
         enable_ff    <= enable_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take_end) begin
         hits_ff <= hits;
         any_ff  <= |hits;
         acc_ff  <= (|hits) | (enable_ff == '0);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_filter_hits = hits_ff;
   assign rsp_any_hit     = any_ff;
   assign rsp_accepted    = acc_ff;

endmodule

/* hw/rtl/gwf_checker.sv */
// Port-level checker for the glob wildcard filter, bound to the top level.
`include "glob_wildcard_filter_macros.svh"

module gwf_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_stall,
   input logic [1:0]                          req_func,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic [gwf_pkg::FILTER_COUNT-1:0]    rsp_filter_hits,
   input logic                                rsp_any_hit,
   input logic                                rsp_accepted
);

   `GWF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)
   `GWF_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall, $stable(rsp_filter_hits))
   `GWF_ASSERT_IMPLY(a_any_hit, clock, reset, rsp_valid, rsp_any_hit == (rsp_filter_hits != '0))
   `GWF_ASSERT_IMPLY(a_hit_accepts, clock, reset, rsp_valid && rsp_any_hit, rsp_accepted)
   `GWF_ASSERT_NEXT(a_end_result, clock, reset, req_valid && !req_stall && req_func == gwf_pkg::FUNC_END, rsp_valid)

endmodule

bind glob_wildcard_filter gwf_checker u_gwf_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .req_func        (req_func),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_filter_hits (rsp_filter_hits),
   .rsp_any_hit     (rsp_any_hit),
   .rsp_accepted    (rsp_accepted)
);
